FILE: hw/rtl/rs485_half_duplex_rx_fifo_defines.svh
// ---------------------------------------------------------------------------
// RS485 receive FIFO assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef RS485_HALF_DUPLEX_RX_FIFO_DEFINES_SVH
`define RS485_HALF_DUPLEX_RX_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds whenever ante holds, in the same cycle.
`define RS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define RS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/rs485rx_pkg.sv
// ---------------------------------------------------------------------------
// RS485 receive FIFO package
// Field widths, command and status codes, request and response structs.
// ---------------------------------------------------------------------------
package rs485rx_pkg;

    localparam int RX_DEPTH_DEF   = 64;
    localparam int MAX_TX_LEN_DEF = 256;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE     = 3'd0,
        CMD_TX_DONE     = 3'd1,
        CMD_LINE_ERROR  = 3'd2,
        CMD_READ        = 3'd3,
        CMD_START_SEND  = 3'd4,
        CMD_RECOVER     = 3'd5,
        CMD_RX_RESET    = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BUSY       = 3'd1,
        ST_LINE_ERROR = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_NO_DATA    = 3'd4,
        ST_BAD_LENGTH = 3'd5
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] rx_byte;
        logic [LEN_W-1:0]  send_length;
    } t_rx_req;

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] read_data;
        logic              drive_transmit;
        logic              tx_busy;
        logic [FILL_W-1:0] fill_level;
    } t_rx_rsp;

endpackage

FILE: hw/rtl/rs485rx_store.sv
// ---------------------------------------------------------------------------
// RS485 receive byte store
// Single write port, one registered read port with write-to-read bypass.
// ---------------------------------------------------------------------------
module rs485rx_store #(
    parameter int RX_DEPTH = rs485rx_pkg::RX_DEPTH_DEF,
    localparam int PW      = $clog2(RX_DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [PW-1:0]                  i_wr_addr,
    input  logic [rs485rx_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [PW-1:0]                  i_rd_addr,
    output logic [rs485rx_pkg::BYTE_W-1:0] o_rd_data
);

    logic [rs485rx_pkg::BYTE_W-1:0] r_mem [RX_DEPTH];
    logic [rs485rx_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // forward a same-cycle write so the read port always mirrors the head
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rs485rx_ctrl.sv
// ---------------------------------------------------------------------------
// RS485 link control
// Pointers, fill count, sticky flags, direction; one request per step.
// ---------------------------------------------------------------------------
module rs485rx_ctrl #(
    parameter int RX_DEPTH   = rs485rx_pkg::RX_DEPTH_DEF,
    parameter int MAX_TX_LEN = rs485rx_pkg::MAX_TX_LEN_DEF,
    localparam int PW        = $clog2(RX_DEPTH),
    localparam int CW        = $clog2(RX_DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  rs485rx_pkg::t_rx_req           i_req,
    input  logic [rs485rx_pkg::BYTE_W-1:0] i_rd_data,
    output rs485rx_pkg::t_rx_rsp           o_rsp,
    output logic                           o_wr_en,
    output logic [PW-1:0]                  o_wr_addr,
    output logic [rs485rx_pkg::BYTE_W-1:0] o_wr_data,
    output logic [PW-1:0]                  o_rd_addr
);

    localparam logic [PW-1:0] LAST_PTR = PW'(RX_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(RX_DEPTH);
    localparam logic [rs485rx_pkg::LEN_W-1:0] MAX_LEN = rs485rx_pkg::LEN_W'(MAX_TX_LEN);

    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_lerr, n_lerr;
    logic          r_busy, n_busy;
    logic          r_dir_tx, n_dir_tx;

    rs485rx_pkg::t_status           status;
    logic [rs485rx_pkg::BYTE_W-1:0] data;
    logic                           push;
    logic [rs485rx_pkg::FILL_W+CW-1:0] fill_ext;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_cnt    = r_cnt;
        n_ovf    = r_ovf;
        n_lerr   = r_lerr;
        n_busy   = r_busy;
        n_dir_tx = r_dir_tx;
        status   = rs485rx_pkg::ST_OK;
        data     = '0;
        push     = 1'b0;

        unique case (rs485rx_pkg::t_cmd'(i_req.cmd))
            rs485rx_pkg::CMD_RX_BYTE: begin
                // drop the byte while the driver owns the line
                if (!r_busy) begin
                    if (r_cnt == FULL_CNT) begin
                        n_rd_ptr = '0;
                        n_wr_ptr = '0;
                        n_cnt    = '0;
                        n_ovf    = 1'b1;
                    end else begin
                        push     = 1'b1;
                        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                    end
                end
            end
            rs485rx_pkg::CMD_TX_DONE: begin
                n_busy   = 1'b0;
                n_dir_tx = 1'b0;
            end
            rs485rx_pkg::CMD_LINE_ERROR: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
                n_cnt    = '0;
                n_lerr   = 1'b1;
            end
            rs485rx_pkg::CMD_READ: begin
                priority if (r_lerr) begin
                    n_lerr = 1'b0;
                    status = rs485rx_pkg::ST_LINE_ERROR;
                end else if (r_ovf) begin
                    n_ovf  = 1'b0;
                    status = rs485rx_pkg::ST_OVERFLOW;
                end else if (r_cnt == '0) begin
                    status = rs485rx_pkg::ST_NO_DATA;
                end else begin
                    data     = i_rd_data;
                    n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
                    n_cnt    = r_cnt - 1'b1;
                end
            end
            rs485rx_pkg::CMD_START_SEND: begin
                priority if ((i_req.send_length == '0) || (i_req.send_length > MAX_LEN)) begin
                    status = rs485rx_pkg::ST_BAD_LENGTH;
                end else if (r_busy) begin
                    status = rs485rx_pkg::ST_BUSY;
                end else begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_cnt    = '0;
                    n_ovf    = 1'b0;
                    n_lerr   = 1'b0;
                    n_busy   = 1'b1;
                    n_dir_tx = 1'b1;
                end
            end
            rs485rx_pkg::CMD_RECOVER: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
                n_cnt    = '0;
                n_ovf    = 1'b0;
                n_lerr   = 1'b0;
                n_busy   = 1'b0;
                n_dir_tx = 1'b0;
            end
            rs485rx_pkg::CMD_RX_RESET: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
                n_cnt    = '0;
                n_ovf    = 1'b0;
                n_lerr   = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_lerr   <= 1'b0;
            r_busy   <= 1'b0;
            r_dir_tx <= 1'b0;
        end else if (i_step) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_lerr   <= n_lerr;
            r_busy   <= n_busy;
            r_dir_tx <= n_dir_tx;
        end
    end

    // fill level is the count masked to the field width
    assign fill_ext = {{rs485rx_pkg::FILL_W{1'b0}}, n_cnt};

    assign o_rsp.status         = status;
    assign o_rsp.read_data      = data;
    assign o_rsp.drive_transmit = n_dir_tx;
    assign o_rsp.tx_busy        = n_busy;
    assign o_rsp.fill_level     = fill_ext[rs485rx_pkg::FILL_W-1:0];

    assign o_wr_en   = i_step && push;
    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = i_req.rx_byte;
    // keep the store read port pointed at the head as it stands after this edge
    assign o_rd_addr = i_step ? n_rd_ptr : r_rd_ptr;

endmodule

FILE: hw/rtl/rs485_half_duplex_rx_fifo.sv
// ---------------------------------------------------------------------------
// RS485 half-duplex receive FIFO controller
// Receive ring FIFO, sticky error flags, transmit-busy and line direction.
// ---------------------------------------------------------------------------
// A request waits in the request register until the control step moves it into
// the result register. Throughput: one request per cycle while the consumer takes results,
//   set by the single control step between the request register and the result register.
// Reset: synchronous, active low; clears pointers, count, flags, direction
//   and both pipeline valids. The byte store is not cleared and needs no pass.
`include "rs485_half_duplex_rx_fifo_defines.svh"

module rs485_half_duplex_rx_fifo #(
    parameter int RX_DEPTH   = rs485rx_pkg::RX_DEPTH_DEF,
    parameter int MAX_TX_LEN = rs485rx_pkg::MAX_TX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rs485rx_pkg::t_rx_req i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rs485rx_pkg::t_rx_rsp o_out_data
);

    localparam int PW = $clog2(RX_DEPTH);

    // Request register: holds the request waiting for the control step.
    logic                 r_req_vld;
    rs485rx_pkg::t_rx_req r_req;

    // Result register: holds the response until the consumer takes it.
    logic                 r_rsp_vld;
    rs485rx_pkg::t_rx_rsp r_rsp;

    rs485rx_pkg::t_rx_rsp           step_rsp;
    logic                           step;
    logic                           wr_en;
    logic [PW-1:0]                  wr_addr;
    logic [rs485rx_pkg::BYTE_W-1:0] wr_data;
    logic [PW-1:0]                  rd_addr;
    logic [rs485rx_pkg::BYTE_W-1:0] rd_data;

    // Advance the held request whenever the result slot is free or draining.
    assign step       = r_req_vld && (!r_rsp_vld || i_out_ready);
    // Take a new request when the request register is empty or moves on.
    assign o_in_ready = !r_req_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_req_vld <= i_in_valid;
            end
            if (step) begin
                r_rsp_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= i_in_data;
        end
        if (step) begin
            r_rsp <= step_rsp;
        end
    end

    // Control step: decode the request, update state, form the response.
    rs485rx_ctrl #(
        .RX_DEPTH   (RX_DEPTH),
        .MAX_TX_LEN (MAX_TX_LEN)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_req     (r_req),
        .i_rd_data (rd_data),
        .o_rsp     (step_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr)
    );

    // Byte store: its registered read always shows the current FIFO head.
    rs485rx_store #(
        .RX_DEPTH (RX_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid = r_rsp_vld;
    assign o_out_data  = r_rsp;

    // A stepped request always lands in the result register.
    `RS_ASSERT_NEXT(a_step_fills_rsp, i_clk, i_rst_n, step, r_rsp_vld, "step lost result")
    // Direction and busy flag move together.
    `RS_ASSERT_SAME(a_dir_tracks_busy, i_clk, i_rst_n, r_rsp_vld, r_rsp.drive_transmit == r_rsp.tx_busy, "direction differs from busy")
    // Only a successful pop carries data.
    `RS_ASSERT_SAME(a_data_only_ok, i_clk, i_rst_n, r_rsp_vld && (r_rsp.status != rs485rx_pkg::ST_OK), r_rsp.read_data == '0, "data on failed request")

endmodule
